// File: src/mlpq_pkg.sv
// Package with the constants, types and codes of the multilevel priority queue.
`timescale 1ns / 1ps
`default_nettype none

package mlpq_pkg;

    localparam int MAX_LEVELS  = 16;
    localparam int LEVEL_DEPTH = 16;
    localparam int TAG_BITS    = 16;

    localparam int LVL_W = 5;
    localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic                go;
        cmd_t                cmd;
        logic [LVL_W-1:0]    prio;
        logic [TAG_BITS-1:0] tag;
    } op_t;

    typedef struct packed {
        logic                claim;
        logic                full;
        logic [TAG_BITS-1:0] tag;
        logic [LVL_W-1:0]    prio;
    } chain_t;

endpackage

`default_nettype wire

// File: src/mlpq_cell.sv
// One priority level: a small FIFO of tags with its pointers, count and chain logic.
`timescale 1ns / 1ps
`default_nettype none

module mlpq_cell
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mlpq_pkg::op_t              op,
    input  wire logic [mlpq_pkg::LVL_W-1:0] level_id,
    input  wire logic                       in_use,
    input  wire mlpq_pkg::chain_t           chain_in,
    output mlpq_pkg::chain_t                chain_out
);

    logic [mlpq_pkg::TAG_BITS-1:0] mem_reg [mlpq_pkg::LEVEL_DEPTH];
    logic [mlpq_pkg::PTR_W-1:0]    rd_ptr_reg;
    logic [mlpq_pkg::PTR_W-1:0]    rd_ptr_next;
    logic [mlpq_pkg::PTR_W-1:0]    wr_ptr_reg;
    logic [mlpq_pkg::PTR_W-1:0]    wr_ptr_next;
    logic [mlpq_pkg::CNT_W-1:0]    count_reg;
    logic [mlpq_pkg::CNT_W-1:0]    count_next;

    logic nonempty;
    logic full;
    logic sel;
    logic take;
    logic do_push;

    localparam logic [mlpq_pkg::PTR_W-1:0] PTR_LAST = mlpq_pkg::PTR_W'(mlpq_pkg::LEVEL_DEPTH - 1);
    localparam logic [mlpq_pkg::CNT_W-1:0] CNT_FULL = mlpq_pkg::CNT_W'(mlpq_pkg::LEVEL_DEPTH);

    always_comb
    begin
        nonempty = (count_reg != '0);
        full     = (count_reg == CNT_FULL);
        sel      = (op.prio == level_id);
        take     = op.go && (op.cmd == mlpq_pkg::CMD_POP) && in_use && nonempty
                   && !chain_in.claim;
        do_push  = op.go && (op.cmd == mlpq_pkg::CMD_PUSH) && sel && in_use && !full;

        chain_out.claim = chain_in.claim || (in_use && nonempty);
        chain_out.full  = chain_in.full || (sel && full);
        chain_out.tag   = take ? mem_reg[rd_ptr_reg] : chain_in.tag;
        chain_out.prio  = take ? level_id : chain_in.prio;

        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        else if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= op.tag;
        end
    end

endmodule

`default_nettype wire

// File: src/multilevel_priority_queue_core.sv
// Top level of the multilevel priority queue: request handshakes, level register and cell chain.
`timescale 1ns / 1ps
`default_nettype none

// The queue holds request tags in one FIFO per priority level, 16 levels of 16 tags each.
// A push (cmd 0) stores its tag at level prio; a pop (cmd 1) returns the oldest tag of the
// highest-numbered nonempty level up to levels_in_use. Every request gives exactly one
// result with a status. A request is taken into an operation register, and when the output
// register is empty or its result is being taken, the request passes the row of level cells,
// where the highest nonempty level claims the pop and hands its tag down the row into the
// output register. A new request is accepted only once the operation register has emptied;
// it may be accepted while a result waits.
// levels_in_use is written through cfg_wr_en and cfg_wr_data; values above 16 act as 16.
module multilevel_priority_queue_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [4:0]  prio,
    input  wire logic [15:0] tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      out_tag,
    output logic [4:0]       out_prio
);

    localparam logic [mlpq_pkg::LVL_W-1:0] LVL_MAX = mlpq_pkg::LVL_W'(mlpq_pkg::MAX_LEVELS);

    logic [4:0]                    levels_reg;
    logic                          op_valid_reg;
    mlpq_pkg::cmd_t                op_cmd_reg;
    logic [mlpq_pkg::LVL_W-1:0]    op_prio_reg;
    logic [mlpq_pkg::TAG_BITS-1:0] op_tag_reg;
    logic                          out_valid_reg;
    mlpq_pkg::status_t             out_status_reg;
    mlpq_pkg::status_t             out_status_next;
    logic [15:0]                   out_tag_reg;
    logic [15:0]                   out_tag_next;
    logic [4:0]                    out_prio_reg;
    logic [4:0]                    out_prio_next;

    logic [mlpq_pkg::LVL_W-1:0] n_eff;
    logic                       go;
    mlpq_pkg::op_t              op;
    mlpq_pkg::chain_t           chain_w [mlpq_pkg::MAX_LEVELS+1];

    assign in_ready  = !op_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_tag   = out_tag_reg;
    assign out_prio  = out_prio_reg;

    assign n_eff = (levels_reg > LVL_MAX) ? LVL_MAX : levels_reg;
    assign go    = op_valid_reg && (!out_valid_reg || out_ready);

    assign op.go   = go;
    assign op.cmd  = op_cmd_reg;
    assign op.prio = op_prio_reg;
    assign op.tag  = op_tag_reg;

    assign chain_w[mlpq_pkg::MAX_LEVELS] = '0;

    for (genvar i = 0; i < mlpq_pkg::MAX_LEVELS; i++)
    begin : g_cell
        localparam logic [mlpq_pkg::LVL_W-1:0] LEVEL_ID = mlpq_pkg::LVL_W'(i + 1);

        mlpq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .level_id  (LEVEL_ID),
            .in_use    (LEVEL_ID <= n_eff),
            .chain_in  (chain_w[i+1]),
            .chain_out (chain_w[i])
        );
    end

    always_comb
    begin
        out_status_next = mlpq_pkg::ST_OK;
        out_tag_next    = '0;
        out_prio_next   = '0;
        if (op_cmd_reg == mlpq_pkg::CMD_POP)
        begin
            if (chain_w[0].claim)
            begin
                out_tag_next  = 16'(chain_w[0].tag);
                out_prio_next = chain_w[0].prio;
            end
            else
            begin
                out_status_next = mlpq_pkg::ST_EMPTY;
            end
        end
        else if ((op_prio_reg == '0) || (op_prio_reg > n_eff))
        begin
            out_status_next = mlpq_pkg::ST_RANGE;
        end
        else if (chain_w[0].full)
        begin
            out_status_next = mlpq_pkg::ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= 5'd16;
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                levels_reg <= cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                op_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                op_valid_reg <= 1'b0;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_cmd_reg  <= mlpq_pkg::cmd_t'(cmd);
            op_prio_reg <= prio;
            op_tag_reg  <= tag[mlpq_pkg::TAG_BITS-1:0];
        end
        if (go)
        begin
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_prio_reg   <= out_prio_next;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("a pending request produced no result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == mlpq_pkg::ST_EMPTY)
        |-> (out_tag_reg == '0) && (out_prio_reg == '0))
        else $error("empty result carries a tag or level");

    a_level_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_prio_reg != '0)
        |-> (out_status_reg == mlpq_pkg::ST_OK) && (out_prio_reg <= LVL_MAX))
        else $error("popped level is inconsistent with the status");

    a_pop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        go && chain_w[0].claim && (op_cmd_reg == mlpq_pkg::CMD_POP)
        |-> (chain_w[0].prio != '0) && (chain_w[0].prio <= n_eff))
        else $error("pop claimed by a level outside the levels in use");

endmodule

`default_nettype wire
